>>> design/ppjs_pkg.sv
// ppjs_pkg: shared constants, types and codes of the processor pool job scheduler.
// No dependencies; imported by every module of the block except ppjs_ram.
`timescale 1ns / 1ps

package ppjs_pkg;

    // Pool and queue sizes
    localparam int MAX_PROCESSORS = 64;
    localparam int MAX_SLOTS      = 64;
    localparam int QUEUE_DEPTH    = 64;

    // Field widths
    localparam int PROC_W  = 7;
    localparam int DUR_W   = 12;
    localparam int TICK_W  = 32;
    localparam int CNT_W   = 32;
    localparam int ENTRY_W = PROC_W + DUR_W;

    // Retire tree shape
    localparam int GROUP_SIZE = 8;
    localparam int NUM_GROUPS = MAX_SLOTS / GROUP_SIZE;
    localparam int GSUM_W     = PROC_W + $clog2(GROUP_SIZE);
    localparam int GCNT_W     = $clog2(GROUP_SIZE + 1);
    localparam int HELD_W     = PROC_W + $clog2(MAX_SLOTS);
    localparam int SLOT_CNT_W = $clog2(MAX_SLOTS + 1);

    // Wait queue
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PROC_W-1:0] POOL_MAX = PROC_W'(MAX_PROCESSORS);

    typedef logic [PROC_W-1:0] proc_t;
    typedef logic [TICK_W-1:0] tick_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_GROUP,
        ST_TOTAL,
        ST_RETIRE,
        ST_HEAD,
        ST_ARRIVE
    } state_t;

    typedef enum logic [1:0] {
        ARR_NONE       = 2'd0,
        ARR_QUEUED     = 2'd1,
        ARR_IMPOSSIBLE = 2'd2,
        ARR_QUEUE_FULL = 2'd3
    } arr_status_t;

    // Broadcast from the sequencer to every slot cell
    typedef struct packed {
        logic  match_en;
        tick_t tick;
        logic  start_en;
        tick_t start_end;
        proc_t start_procs;
    } cell_ctl_t;

endpackage

>>> design/ppjs_ram.sv
// ppjs_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ppjs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/ppjs_cell.sv
// ppjs_cell: one job slot of the slot chain (valid, end tick, processors held).
// Depends on ppjs_pkg. The free-slot grant ripples from cell to cell.
`timescale 1ns / 1ps

module ppjs_cell
    import ppjs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_ctl_t ctl,
    input  logic      grant_in,
    output logic      grant_out,
    output logic      valid,
    output proc_t     hit_procs
);

    logic  valid_reg, valid_next;
    logic  hit_reg, hit_next;
    tick_t end_reg;
    proc_t procs_reg;
    logic  take;
    logic  ends_now;

    assign ends_now  = ctl.match_en && valid_reg && (end_reg == ctl.tick);
    assign take      = ctl.start_en && grant_in && !valid_reg;
    assign grant_out = grant_in && valid_reg;
    assign valid     = valid_reg;
    assign hit_procs = hit_reg ? procs_reg : '0;

    always_comb begin
        hit_next   = ends_now;
        valid_next = valid_reg;
        if (ends_now) begin
            valid_next = 1'b0;
        end else if (take) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            end_reg   <= ctl.start_end;
            procs_reg <= ctl.start_procs;
        end
    end

endmodule

>>> design/ppjs_tree.sv
// ppjs_tree: two-level registered sum of retiring slots (processors and count).
// Depends on ppjs_pkg. Cell hit flags are summed into group registers, then into the total registers.
`timescale 1ns / 1ps

module ppjs_tree
    import ppjs_pkg::*;
(
    input  logic                  aclk,
    input  proc_t                 hit_procs [MAX_SLOTS],
    output logic [HELD_W-1:0]     sum,
    output logic [SLOT_CNT_W-1:0] cnt
);

    logic [GSUM_W-1:0]     gsum_reg [NUM_GROUPS];
    logic [GCNT_W-1:0]     gcnt_reg [NUM_GROUPS];
    logic [GSUM_W-1:0]     gsum_next [NUM_GROUPS];
    logic [GCNT_W-1:0]     gcnt_next [NUM_GROUPS];
    logic [HELD_W-1:0]     sum_reg, sum_next;
    logic [SLOT_CNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            gsum_next[g] = '0;
            gcnt_next[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                gsum_next[g] = gsum_next[g] + GSUM_W'(hit_procs[g*GROUP_SIZE+k]);
                gcnt_next[g] = gcnt_next[g]
                             + GCNT_W'(hit_procs[g*GROUP_SIZE+k] != '0);
            end
        end
    end

    always_comb begin
        sum_next = '0;
        cnt_next = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            sum_next = sum_next + HELD_W'(gsum_reg[g]);
            cnt_next = cnt_next + SLOT_CNT_W'(gcnt_reg[g]);
        end
    end

    always_ff @(posedge aclk) begin
        gsum_reg <= gsum_next;
        gcnt_reg <= gcnt_next;
        sum_reg  <= sum_next;
        cnt_reg  <= cnt_next;
    end

    assign sum = sum_reg;
    assign cnt = cnt_reg;

endmodule

>>> design/processor_pool_job_scheduler.sv
// processor_pool_job_scheduler: top level, tick sequencer, pool counters, wait queue.
// Depends on ppjs_pkg, ppjs_ram, ppjs_cell, ppjs_tree.
//
//  channel  | dir | tdata (low bit up)                          | tuser
//  ---------+-----+---------------------------------------------+-----------------
//  s_       | in  | job_processors[6:0], job_duration[18:7]     | job_arrives[0]
//  m_       | out | free[6:0] tick[38:7] done[70:39]            | arrival_status
//           |     | idle[102:71] queue_length[109:103]          | [1:0]
//  cfg_     | in  | cfg_wdata[6:0] = total_processors, no read  | -
//
// One item (one tick) passes the steps accept, slot compare, two retire tree
// levels, retire update, queue head start, arrival start, in order. The retire
// adder tree over the 64-slot chain and the ordered head/arrival starts set them.
// Reset (aresetn low, synchronous) empties all slots and the queue; pool is 1.
// A result waits in the output register; the next item is accepted while it
// waits, and the block stalls only in the arrival step if the register is full.
`timescale 1ns / 1ps

module processor_pool_job_scheduler
    import ppjs_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // config
    input  logic         cfg_we,
    input  logic [6:0]   cfg_wdata,      // total_processors
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,        // job_processors[6:0], job_duration[18:7]
    input  logic [0:0]   s_tuser,        // job_arrives[0]
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,        // free, tick, done, idle, queue_length
    output logic [1:0]   m_tuser         // arrival_status[1:0]
);

    // ---------------------------------------------------------------- state
    state_t state_reg, state_next;

    tick_t                 tick_reg;
    logic [CNT_W-1:0]      done_reg;
    logic [CNT_W-1:0]      idle_reg;
    proc_t                 free_reg;
    proc_t                 total_reg;
    logic [HELD_W-1:0]     held_reg;      // processors held by running jobs
    logic [SLOT_CNT_W-1:0] running_reg;   // busy slots
    logic [QPTR_W-1:0]     head_reg;
    logic [QPTR_W-1:0]     tail_reg;
    logic [QCNT_W-1:0]     qcount_reg;

    // latched input item (already normalized)
    logic               arr_reg;
    proc_t              jprocs_reg;
    logic [DUR_W-1:0]   jdur_reg;

    // output register
    logic               m_tvalid_reg;
    proc_t              o_free_reg;
    tick_t              o_tick_reg;
    logic [CNT_W-1:0]   o_done_reg;
    logic [CNT_W-1:0]   o_idle_reg;
    logic [QCNT_W-1:0]  o_qlen_reg;
    arr_status_t        o_status_reg;

    // ---------------------------------------------------------------- decode
    logic             s_accept;
    proc_t            in_procs;
    logic [DUR_W-1:0] in_dur;

    assign s_accept = s_tvalid && s_tready;
    // zero processors or zero duration count as one
    assign in_procs = (s_tdata[6:0] == '0) ? PROC_W'(1) : s_tdata[6:0];
    assign in_dur   = (s_tdata[18:7] == '0) ? DUR_W'(1) : s_tdata[18:7];

    // ---------------------------------------------------------------- slot chain
    cell_ctl_t cell_ctl;
    logic      grant [MAX_SLOTS+1];
    logic [MAX_SLOTS-1:0] slot_valid;
    proc_t     hit_procs [MAX_SLOTS];

    assign grant[0] = 1'b1;

    for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
        ppjs_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (cell_ctl),
            .grant_in  (grant[i]),
            .grant_out (grant[i+1]),
            .valid     (slot_valid[i]),
            .hit_procs (hit_procs[i])
        );
    end

    logic [HELD_W-1:0]     ret_sum;
    logic [SLOT_CNT_W-1:0] ret_cnt;

    ppjs_tree u_tree (
        .aclk      (aclk),
        .hit_procs (hit_procs),
        .sum       (ret_sum),
        .cnt       (ret_cnt)
    );

    // ---------------------------------------------------------------- wait queue
    logic               q_we;
    logic [ENTRY_W-1:0] q_rdata;
    proc_t              head_procs;
    logic [DUR_W-1:0]   head_dur;

    // head address changes only in the head step and is stable before the next one
    ppjs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk  (aclk),
        .we    (q_we),
        .waddr (tail_reg),
        .wdata ({jprocs_reg, jdur_reg}),
        .raddr (head_reg),
        .rdata (q_rdata)
    );

    assign head_procs = q_rdata[ENTRY_W-1:DUR_W];
    assign head_dur   = q_rdata[DUR_W-1:0];

    // ---------------------------------------------------------------- decisions
    logic        slot_free;
    logic        head_go;
    logic        arr_fit;
    logic        out_free;
    logic        arr_leave;
    arr_status_t arr_status;
    logic [PROC_W:0] free_sum_clip;
    logic [HELD_W:0] free_plus;

    assign slot_free = (running_reg != SLOT_CNT_W'(MAX_SLOTS));
    assign head_go   = (state_reg == ST_HEAD) && (qcount_reg != '0)
                    && (free_reg >= head_procs) && slot_free;
    assign arr_fit   = arr_reg && (free_reg >= jprocs_reg) && slot_free;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign arr_leave = (state_reg == ST_ARRIVE) && out_free;

    // returned processors saturate at the pool size
    assign free_plus = (HELD_W+1)'(free_reg) + (HELD_W+1)'(ret_sum);
    assign free_sum_clip = (free_plus > (HELD_W+1)'(total_reg))
                         ? (PROC_W+1)'(total_reg) : free_plus[PROC_W:0];

    always_comb begin
        priority if (!arr_reg || arr_fit) begin
            arr_status = ARR_NONE;
        end else if (running_reg == '0) begin
            arr_status = ARR_IMPOSSIBLE;
        end else if (qcount_reg == QCNT_W'(QUEUE_DEPTH)) begin
            arr_status = ARR_QUEUE_FULL;
        end else begin
            arr_status = ARR_QUEUED;
        end
    end

    // ---------------------------------------------------------------- next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_accept) state_next = ST_MATCH;
            ST_MATCH:  state_next = ST_GROUP;
            ST_GROUP:  state_next = ST_TOTAL;
            ST_TOTAL:  state_next = ST_RETIRE;
            ST_RETIRE: state_next = ST_HEAD;
            ST_HEAD:   state_next = ST_ARRIVE;
            ST_ARRIVE: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- outputs of the sequencer
    always_comb begin
        s_tready             = (state_reg == ST_IDLE);
        cell_ctl.match_en    = (state_reg == ST_MATCH);
        cell_ctl.tick        = tick_reg;
        cell_ctl.start_en    = head_go || (arr_leave && arr_fit);
        if (state_reg == ST_HEAD) begin
            cell_ctl.start_end   = tick_reg + TICK_W'(head_dur);
            cell_ctl.start_procs = head_procs;
        end else begin
            cell_ctl.start_end   = tick_reg + TICK_W'(jdur_reg);
            cell_ctl.start_procs = jprocs_reg;
        end
        q_we = arr_leave && (arr_status == ARR_QUEUED);
    end

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tick_reg     <= '0;
            done_reg     <= '0;
            idle_reg     <= '0;
            free_reg     <= PROC_W'(1);
            total_reg    <= PROC_W'(1);
            held_reg     <= '0;
            running_reg  <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            qcount_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                // clamp to 1..pool max; free = pool minus held, floored at zero
                logic [HELD_W-1:0] v;
                v = (cfg_wdata == '0) ? HELD_W'(1)
                  : (cfg_wdata > POOL_MAX) ? HELD_W'(POOL_MAX) : HELD_W'(cfg_wdata);
                total_reg <= v[PROC_W-1:0];
                free_reg  <= (held_reg < v) ? PROC_W'(v - held_reg) : '0;
            end

            if (s_accept) begin
                tick_reg <= tick_reg + TICK_W'(1);
            end

            if (state_reg == ST_RETIRE) begin
                free_reg    <= free_sum_clip[PROC_W-1:0];
                done_reg    <= done_reg + CNT_W'(ret_cnt);
                running_reg <= running_reg - ret_cnt;
                held_reg    <= held_reg - ret_sum;
            end

            if (head_go) begin
                free_reg    <= free_reg - head_procs;
                held_reg    <= held_reg + HELD_W'(head_procs);
                running_reg <= running_reg + SLOT_CNT_W'(1);
                head_reg    <= (head_reg == QPTR_W'(QUEUE_DEPTH - 1))
                             ? '0 : head_reg + QPTR_W'(1);
                qcount_reg  <= qcount_reg - QCNT_W'(1);
            end

            if (arr_leave) begin
                if (arr_fit) begin
                    free_reg    <= free_reg - jprocs_reg;
                    held_reg    <= held_reg + HELD_W'(jprocs_reg);
                    running_reg <= running_reg + SLOT_CNT_W'(1);
                end
                if (q_we) begin
                    tail_reg   <= (tail_reg == QPTR_W'(QUEUE_DEPTH - 1))
                                ? '0 : tail_reg + QPTR_W'(1);
                    qcount_reg <= qcount_reg + QCNT_W'(1);
                end
                if ((running_reg == '0) && !arr_fit) begin
                    idle_reg <= idle_reg + CNT_W'(1);
                end
            end

            if (arr_leave) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            arr_reg    <= s_tuser[0];
            jprocs_reg <= in_procs;
            jdur_reg   <= in_dur;
        end
        if (arr_leave) begin
            o_free_reg   <= arr_fit ? free_reg - jprocs_reg : free_reg;
            o_tick_reg   <= tick_reg;
            o_done_reg   <= done_reg;
            o_idle_reg   <= ((running_reg == '0) && !arr_fit)
                          ? idle_reg + CNT_W'(1) : idle_reg;
            o_qlen_reg   <= q_we ? qcount_reg + QCNT_W'(1) : qcount_reg;
            o_status_reg <= arr_status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, 7'(o_qlen_reg), o_idle_reg, o_done_reg, o_tick_reg,
                       o_free_reg};
    assign m_tuser  = o_status_reg;

    // ---------------------------------------------------------------- assertions
    // busy-slot counter tracks the cells between ticks
    a_running_matches_cells: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> ($countones(slot_valid) == 32'(running_reg)))
        else $error("running slot count disagrees with slot cells");

    // free processors never exceed the pool
    a_free_within_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (free_reg <= total_reg))
        else $error("free processors above pool size");

    // a head start consumes exactly the head job's processors
    a_head_start_debit: assert property (@(posedge aclk) disable iff (!aresetn)
        head_go |=> (free_reg == $past(free_reg) - $past(head_procs)))
        else $error("head start did not debit free processors");

    // queue never holds more than its depth
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (qcount_reg == QCNT_W'(QUEUE_DEPTH)) |=> (qcount_reg <= QCNT_W'(QUEUE_DEPTH)))
        else $error("wait queue overflow");

endmodule
